/* rtl/wbss_pkg.sv */
// shared constants, types and register codes of the wildcard byte signature scanner
package wbss_pkg;

    localparam int MAX_PATTERN_BYTES = 16;
    localparam int WIN_IDX_W         = $clog2(MAX_PATTERN_BYTES);
    localparam int LEN_W             = 5;
    localparam int ADDR_W            = 32;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 64;
    localparam int MASK_W            = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW    = 3'd0,
        REG_PATTERN_HIGH   = 3'd1,
        REG_CARE_MASK      = 3'd2,
        REG_PATTERN_LENGTH = 3'd3,
        REG_BASE_ADDRESS   = 3'd4
    } cfg_reg_e;

    // pattern laid out against the window: entry j faces window cell j
    typedef struct packed {
        logic [MAX_PATTERN_BYTES-1:0][7:0] pattern;
        logic [MAX_PATTERN_BYTES-1:0]      care;
        logic [WIN_IDX_W-1:0]              len_m1;
        logic                              len_zero;
        logic [ADDR_W-1:0]                 base;
    } wbss_align_t;

endpackage

/* rtl/wbss_if.sv */
// channel interfaces: byte input, result output and configuration write
interface wbss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       region_start;
    logic       region_end;

    modport source (output valid, output data_byte, output region_start,
                    output region_end, input ready);
    modport sink   (input valid, input data_byte, input region_start,
                    input region_end, output ready);
endinterface

interface wbss_out_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic        first_hit;
    logic [31:0] match_address;
    logic        region_done_no_hit;

    modport source (output valid, output hit, output first_hit,
                    output match_address, output region_done_no_hit, input ready);
    modport sink   (input valid, input hit, input first_hit,
                    input match_address, input region_done_no_hit, output ready);
endinterface

interface wbss_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/wbss_cfg_regs.sv */
// configuration registers and alignment of the pattern to the window cells
module wbss_cfg_regs
    import wbss_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output wbss_align_t            align
);

    logic [CFG_DATA_W-1:0] pattern_low_reg;
    logic [CFG_DATA_W-1:0] pattern_high_reg;
    logic [MASK_W-1:0]     care_mask_reg;
    logic [LEN_W-1:0]      pattern_length_reg;
    logic [ADDR_W-1:0]     base_address_reg;

    logic [2*CFG_DATA_W-1:0] full_pattern;
    logic [LEN_W-1:0]        eff_len;
    logic [WIN_IDX_W-1:0]    len_m1;
    logic [WIN_IDX_W-1:0]    src_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            care_mask_reg      <= '1;
            pattern_length_reg <= LEN_W'(1);
            base_address_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_PATTERN_LOW:    pattern_low_reg    <= wr_data;
                REG_PATTERN_HIGH:   pattern_high_reg   <= wr_data;
                REG_CARE_MASK:      care_mask_reg      <= wr_data[MASK_W-1:0];
                REG_PATTERN_LENGTH: pattern_length_reg <= wr_data[LEN_W-1:0];
                REG_BASE_ADDRESS:   base_address_reg   <= wr_data[ADDR_W-1:0];
                default:            ;
            endcase
        end
    end

    assign full_pattern = {pattern_high_reg, pattern_low_reg};

    // lengths above the window size act as the window size
    assign eff_len = (pattern_length_reg > LEN_W'(MAX_PATTERN_BYTES))
                   ? LEN_W'(MAX_PATTERN_BYTES) : pattern_length_reg;
    assign len_m1  = WIN_IDX_W'(eff_len - LEN_W'(1));

    // window cell j holds pattern byte len-1-j; cells past the length are wildcards
    always_comb
    begin
        align.len_m1   = len_m1;
        align.len_zero = (pattern_length_reg == '0);
        align.base     = base_address_reg;
        for (int j = 0; j < MAX_PATTERN_BYTES; j++)
        begin
            src_idx          = len_m1 - WIN_IDX_W'(j);
            align.pattern[j] = full_pattern[src_idx*8 +: 8];
            align.care[j]    = care_mask_reg[src_idx] && (WIN_IDX_W'(j) <= len_m1);
        end
    end

endmodule

/* rtl/wbss_cell.sv */
// one window cell: holds a byte and its fill flag, compares against its pattern byte
module wbss_cell
    import wbss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic       clear,
    input  logic [7:0] prev_byte,
    input  logic       prev_valid,
    input  logic [7:0] pat_byte,
    input  logic       care,
    output logic [7:0] byte_q,
    output logic       valid_q,
    output logic       valid_next,
    output logic       match_next
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       valid_reg;

    // byte this cell holds once the incoming transaction is taken in
    assign byte_next  = clear ? 8'h00 : prev_byte;
    assign valid_next = clear ? 1'b0  : prev_valid;
    assign match_next = !care || (byte_next == pat_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            byte_reg  <= byte_next;
            valid_reg <= valid_next;
        end
    end

    assign byte_q  = byte_reg;
    assign valid_q = valid_reg;

endmodule

/* rtl/wildcard_byte_signature_scanner.sv */
// top level of the wildcard byte signature scanner
// Bytes enter a row of 16 window cells, one byte per cycle, and every accepted byte
// gives exactly one result transaction, registered and offered on the cycle after
// acceptance. All cells compare against the configured pattern in parallel, so a new
// byte can be taken every cycle as long as the previous result leaves the output
// register in the same cycle; a result held by the receiver holds off the input until
// it is taken. The pattern is aligned so that its last byte faces the newest window
// cell; care_mask bits that are clear make wildcards, and overlapping matches are all
// reported with the address base_address + offset of the first matched byte.
// Configuration writes are always ready and must be made while no byte is in flight.
module wildcard_byte_signature_scanner
    import wbss_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    wbss_in_if.sink    byte_in,
    wbss_out_if.source result_out,
    wbss_cfg_if.sink   cfg
);

    wbss_align_t align;

    logic                         accept;
    logic [MAX_PATTERN_BYTES-1:0] match_vec;
    logic [MAX_PATTERN_BYTES-1:0] valid_vec;
    logic [MAX_PATTERN_BYTES-1:0] valid_q_vec;
    logic [MAX_PATTERN_BYTES-1:0][7:0] byte_q_vec;

    logic [ADDR_W-1:0] offset_reg;
    logic [ADDR_W-1:0] offset_next;
    logic [ADDR_W-1:0] cur_offset;
    logic              hit_seen_reg;
    logic              hit_seen_next;
    logic              prior_seen;
    logic              hit_now;

    logic              out_valid_reg;
    logic              out_hit_reg;
    logic              out_first_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic              out_done_reg;

    assign cfg.ready = 1'b1;

    wbss_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid && cfg.ready),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .align    (align)
    );

    assign byte_in.ready = !out_valid_reg || result_out.ready;
    assign accept        = byte_in.valid && byte_in.ready;

    genvar j;
    generate
        for (j = 0; j < MAX_PATTERN_BYTES; j++)
        begin : g_cell
            logic [7:0] prev_byte;
            logic       prev_valid;
            logic       clear;

            if (j == 0)
            begin : g_head
                assign prev_byte  = byte_in.data_byte;
                assign prev_valid = 1'b1;
                assign clear      = 1'b0;
            end
            else
            begin : g_body
                assign prev_byte  = byte_q_vec[j-1];
                assign prev_valid = valid_q_vec[j-1];
                // a region start empties every cell but the one the new byte lands in
                assign clear      = byte_in.region_start;
            end

            wbss_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .advance    (accept),
                .clear      (clear),
                .prev_byte  (prev_byte),
                .prev_valid (prev_valid),
                .pat_byte   (align.pattern[j]),
                .care       (align.care[j]),
                .byte_q     (byte_q_vec[j]),
                .valid_q    (valid_q_vec[j]),
                .valid_next (valid_vec[j]),
                .match_next (match_vec[j])
            );
        end
    endgenerate

    // enough bytes seen exactly when the oldest cell the pattern reaches is filled
    assign hit_now       = !align.len_zero && valid_vec[align.len_m1] && (&match_vec);
    assign cur_offset    = byte_in.region_start ? '0 : offset_reg;
    assign offset_next   = cur_offset + ADDR_W'(1);
    assign prior_seen    = byte_in.region_start ? 1'b0 : hit_seen_reg;
    assign hit_seen_next = prior_seen || hit_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            hit_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                offset_reg    <= offset_next;
                hit_seen_reg  <= hit_seen_next;
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_hit_reg   <= hit_now;
            out_first_reg <= hit_now && !prior_seen;
            out_addr_reg  <= hit_now
                           ? align.base + cur_offset - ADDR_W'(align.len_m1)
                           : '0;
            out_done_reg  <= byte_in.region_end && !hit_seen_next;
        end
    end

    assign result_out.valid              = out_valid_reg;
    assign result_out.hit                = out_hit_reg;
    assign result_out.first_hit          = out_first_reg;
    assign result_out.match_address      = out_addr_reg;
    assign result_out.region_done_no_hit = out_done_reg;

endmodule
